@@ rtl/ct3_pkg.sv @@
// ----------------------------------------------------------------------------
// ct3_pkg
// Shared types and constants for the 3x3 census transform stream block.
// ----------------------------------------------------------------------------
package ct3_pkg;

    // Default frame limits (line store depth, row counter range)
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;

    // Smallest frame side that still has an interior centre
    localparam int MIN_DIM = 3;

    // Register file
    localparam int REG_WIDTH_W  = 11;
    localparam int REG_HEIGHT_W = 13;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    localparam logic [REG_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
    localparam logic [REG_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    typedef enum logic
    {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } ct3_reg_t;

    // Result field widths
    localparam int PIX_W  = 8;
    localparam int CODE_W = 8;
    localparam int ROW_OUT_W = 12;
    localparam int COL_OUT_W = 10;
    localparam int OUT_DATA_W = 32;   // 30 bits of fields, padded to bytes

    // Per-beat tag computed at accept time and carried down the pipe
    typedef struct packed
    {
        logic                 emit;   // interior centre, produce a result
        logic                 last;   // final interior centre of the frame
        logic [ROW_OUT_W-1:0] row;    // centre row
        logic [COL_OUT_W-1:0] col;    // centre column
    } ct3_tag_t;

endpackage

@@ rtl/ct3_core.sv @@
// ----------------------------------------------------------------------------
// ct3_core
// Line stores, 3x3 window and census compare with an output register.
// ----------------------------------------------------------------------------
module ct3_core #(
    parameter int MAX_WIDTH = ct3_pkg::DEF_MAX_WIDTH,
    parameter int COL_W     = $clog2(MAX_WIDTH)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ct3_pkg::PIX_W-1:0]      in_pixel,
    input  logic [COL_W-1:0]               in_addr,
    input  ct3_pkg::ct3_tag_t              in_tag,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ct3_pkg::CODE_W-1:0]     out_code,
    output logic [ct3_pkg::ROW_OUT_W-1:0]  out_row,
    output logic [ct3_pkg::COL_OUT_W-1:0]  out_col,
    output logic                           out_last
);

    logic [ct3_pkg::PIX_W-1:0] upper_mem  [MAX_WIDTH];
    logic [ct3_pkg::PIX_W-1:0] middle_mem [MAX_WIDTH];

    logic [ct3_pkg::PIX_W-1:0] top_reg;
    logic [ct3_pkg::PIX_W-1:0] mid_reg;

    logic                      s1_valid_reg;
    logic                      s1_valid_next;
    logic [ct3_pkg::PIX_W-1:0] s1_pixel_reg;
    logic [COL_W-1:0]          s1_addr_reg;
    ct3_pkg::ct3_tag_t         s1_tag_reg;

    // window: 0..2 left column (top, mid, bottom), 3..5 centre column
    logic [ct3_pkg::PIX_W-1:0] win_reg [6];

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [ct3_pkg::CODE_W-1:0] out_code_reg;
    logic [ct3_pkg::ROW_OUT_W-1:0] out_row_reg;
    logic [ct3_pkg::COL_OUT_W-1:0] out_col_reg;
    logic                       out_last_reg;

    logic                       accept;
    logic                       out_free;
    logic                       s1_go;
    logic [ct3_pkg::PIX_W-1:0]  nb [8];
    logic [ct3_pkg::CODE_W-1:0] code;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign s1_go    = s1_valid_reg && (!s1_tag_reg.emit || out_free);
    assign in_ready = !s1_valid_reg || s1_go;

    // Read at accept, write back as the beat leaves s1. Consecutive beats hit
    // different columns (width >= 3), so read and write never collide.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            top_reg <= upper_mem[in_addr];
            mid_reg <= middle_mem[in_addr];
        end
        if (s1_go)
        begin
            upper_mem[s1_addr_reg]  <= mid_reg;
            middle_mem[s1_addr_reg] <= s1_pixel_reg;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= in_pixel;
            s1_addr_reg  <= in_addr;
            s1_tag_reg   <= in_tag;
        end
    end

    // Neighbours TL, T, TR, L, R, BL, B, BR; TL ends up in the MSB
    always_comb
    begin
        nb[0] = win_reg[0];
        nb[1] = win_reg[3];
        nb[2] = top_reg;
        nb[3] = win_reg[1];
        nb[4] = mid_reg;
        nb[5] = win_reg[2];
        nb[6] = win_reg[5];
        nb[7] = s1_pixel_reg;
        for (int k = 0; k < 8; k++)
            code[7-k] = (nb[k] >= win_reg[4]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else if (s1_go)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top_reg;
            win_reg[4] <= mid_reg;
            win_reg[5] <= s1_pixel_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_go && s1_tag_reg.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_tag_reg.emit)
        begin
            out_code_reg <= code;
            out_row_reg  <= s1_tag_reg.row;
            out_col_reg  <= s1_tag_reg.col;
            out_last_reg <= s1_tag_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_code  = out_code_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_last  = out_last_reg;

endmodule

@@ rtl/census_transform_3x3_stream.sv @@
// ----------------------------------------------------------------------------
// census_transform_3x3_stream
// 3x3 census transform over a raster pixel stream with APB frame setup.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the s_* stream in raster order, one per beat, frame
//   after frame with no gaps in the numbering. Each interior centre gives
//   one m_* beat: its census code (bit set when neighbour >= centre, TL
//   neighbour in the MSB) with centre row and column; m_tlast marks the
//   final interior centre of the frame. Border pixels give no beat.
//   Frame width and height are set over APB (0x0 width, 0x4 height); a
//   write restarts the frame at row 0, column 0. Out-of-range sizes are
//   saturated to [3, MAX_WIDTH] and [3, MAX_HEIGHT]. Write only when idle.
// Timing:
//   One pixel per cycle while m_tready stays high. The pixel completing
//   a window enters the s1 registers with its line store reads; its compare
//   goes into the output register behind m_tvalid once that is free. Each
//   line store has one read and one write port per cycle.
// Reset and stall:
//   Reset clears the counters, the window and the valid flags; width and
//   height return to 640 and 480. Line store contents are not cleared.
//   If m_tready stays low, the output register holds its beat and the
//   pipe fills; s_tready drops once a second result is waiting.
// ----------------------------------------------------------------------------
module census_transform_3x3_stream #(
    parameter int MAX_WIDTH  = ct3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ct3_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ct3_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ct3_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ct3_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    // pixel input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ct3_pkg::PIX_W-1:0]         s_tdata,  // [7:0] pixel
    // census result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ct3_pkg::OUT_DATA_W-1:0]    m_tdata,  // [7:0] census_code,
                                                        // [19:8] center_row,
                                                        // [29:20] center_column,
                                                        // [31:30] zero
    output logic                              m_tlast   // frame_last
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    logic [ct3_pkg::REG_WIDTH_W-1:0]  frame_width_reg;
    logic [ct3_pkg::REG_HEIGHT_W-1:0] frame_height_reg;
    logic [COL_W-1:0]                 col_reg;
    logic [COL_W-1:0]                 col_next;
    logic [ROW_W-1:0]                 row_reg;
    logic [ROW_W-1:0]                 row_next;

    logic             cfg_wr;
    ct3_pkg::ct3_reg_t cfg_sel;
    logic             accept;
    logic [COL_W-1:0] w_m1;
    logic [ROW_W-1:0] h_m1;
    logic [COL_W-1:0] col_m1;
    logic [ROW_W-1:0] row_m1;
    ct3_pkg::ct3_tag_t tag;

    logic [ct3_pkg::CODE_W-1:0]    res_code;
    logic [ct3_pkg::ROW_OUT_W-1:0] res_row;
    logic [ct3_pkg::COL_OUT_W-1:0] res_col;

    // ---------------- configuration ----------------
    assign pready  = 1'b1;
    assign cfg_sel = ct3_pkg::ct3_reg_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= ct3_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= ct3_pkg::FRAME_HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                ct3_pkg::REG_FRAME_WIDTH:
                    frame_width_reg  <= pwdata[ct3_pkg::REG_WIDTH_W-1:0];
                ct3_pkg::REG_FRAME_HEIGHT:
                    frame_height_reg <= pwdata[ct3_pkg::REG_HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            ct3_pkg::REG_FRAME_WIDTH:  prdata = 32'(frame_width_reg);
            ct3_pkg::REG_FRAME_HEIGHT: prdata = 32'(frame_height_reg);
            default:                   prdata = '0;
        endcase
    end

    // effective last column / last row after saturation
    always_comb
    begin
        if (32'(frame_width_reg) < ct3_pkg::MIN_DIM)
            w_m1 = COL_W'(ct3_pkg::MIN_DIM - 1);
        else if (32'(frame_width_reg) > MAX_WIDTH)
            w_m1 = COL_W'(MAX_WIDTH - 1);
        else
            w_m1 = COL_W'(32'(frame_width_reg) - 1);

        if (32'(frame_height_reg) < ct3_pkg::MIN_DIM)
            h_m1 = ROW_W'(ct3_pkg::MIN_DIM - 1);
        else if (32'(frame_height_reg) > MAX_HEIGHT)
            h_m1 = ROW_W'(MAX_HEIGHT - 1);
        else
            h_m1 = ROW_W'(32'(frame_height_reg) - 1);
    end

    // ---------------- raster position ----------------
    assign accept = s_tvalid && s_tready;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_wr)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_reg == w_m1)
            begin
                col_next = '0;
                row_next = (row_reg == h_m1) ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // The incoming pixel is the bottom-right of the window centred one
    // row up and one column left.
    assign col_m1   = col_reg - COL_W'(1);
    assign row_m1   = row_reg - ROW_W'(1);
    assign tag.emit = (32'(row_reg) >= 2) && (32'(col_reg) >= 2);
    assign tag.last = (row_reg == h_m1) && (col_reg == w_m1);
    assign tag.row  = ct3_pkg::ROW_OUT_W'(row_m1);
    assign tag.col  = ct3_pkg::COL_OUT_W'(col_m1);

    // ---------------- window pipe ----------------
    ct3_core #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pixel  (s_tdata),
        .in_addr   (col_reg),
        .in_tag    (tag),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_code  (res_code),
        .out_row   (res_row),
        .out_col   (res_col),
        .out_last  (m_tlast)
    );

    assign m_tdata = {2'b00, res_col, res_row, res_code};

endmodule

@@ rtl/ct3_checker.sv @@
// ----------------------------------------------------------------------------
// ct3_checker
// Port-level checks for the census transform stream, bound to the top level.
// ----------------------------------------------------------------------------
module ct3_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    // a held result is not dropped
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // a held result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result payload changed while stalled");

    // input back-pressure only comes from a stalled output
    a_bp_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output back-pressure");

    // no result for row 0 or column 0, padding bits are zero
    a_interior: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[19:8] != 12'd0) && (m_tdata[29:20] != 10'd0)
                     && (m_tdata[31:30] == 2'b00))
        else $error("border centre or bad padding on result");

endmodule

bind census_transform_3x3_stream ct3_checker u_ct3_checker (.*);

@@ sim/census_transform_3x3_stream_tb.sv @@
// ----------------------------------------------------------------------------
// census_transform_3x3_stream_tb
// Self-checking bench for the 3x3 census transform stream block: frames of
// assorted sizes go in over the pixel stream, every census beat out is
// checked against an in-bench window predictor, with random idling on both
// streams and frame setup over APB between phases.
// ----------------------------------------------------------------------------
module census_transform_3x3_stream_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_W_MAX   = ct3_pkg::DEF_MAX_WIDTH;
    localparam int FRAME_H_MAX   = ct3_pkg::DEF_MAX_HEIGHT;
    localparam int PIPE_SLACK    = 8;      // settle time after the result queue drains
    localparam int HOLD_CYCLES   = 300;    // long receiver hold-off
    localparam int STALL_LIMIT   = 2000;   // cycles with no handshake at all
    localparam int RANDOM_PIXELS = 450;
    localparam int WIDE_W        = 200;    // wide frame, column bits up to 7
    localparam int TALL_H        = 60;     // tall frame on a narrow width

    // pixel content styles for a frame
    typedef enum int unsigned
    {
        STYLE_UNIFORM,   // anything goes
        STYLE_FLAT,      // level +/- 1, lots of equal compares
        STYLE_EXTREME    // only 0 and 255
    } pixel_style_t;

    // receiver ready behaviour, changes every so often
    typedef enum int unsigned
    {
        READY_ALWAYS,
        READY_MOSTLY,
        READY_SPARSE,
        READY_PERIODIC
    } ready_mode_t;

    typedef struct
    {
        logic [ct3_pkg::CODE_W-1:0]    code;
        logic [ct3_pkg::ROW_OUT_W-1:0] row;
        logic [ct3_pkg::COL_OUT_W-1:0] col;
        logic                          last;
    } census_result_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [ct3_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [ct3_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [ct3_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [ct3_pkg::PIX_W-1:0]      s_tdata = '0;   // [7:0] pixel
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [ct3_pkg::OUT_DATA_W-1:0] m_tdata;        // [7:0] census_code,
                                                    // [19:8] center_row,
                                                    // [29:20] center_column,
                                                    // [31:30] zero
    logic                           m_tlast;        // frame_last

    // predictor state: mirrors the line stores, the window and the raster position
    logic [ct3_pkg::PIX_W-1:0]        upper_line [FRAME_W_MAX];
    logic [ct3_pkg::PIX_W-1:0]        middle_line [FRAME_W_MAX];
    logic [ct3_pkg::PIX_W-1:0]        window [6];   // left col (t,m,b), centre col (t,m,b)
    int unsigned                      col_pos = 0;
    int unsigned                      row_pos = 0;
    logic [ct3_pkg::REG_WIDTH_W-1:0]  frame_width_reg  = ct3_pkg::FRAME_WIDTH_RST;
    logic [ct3_pkg::REG_HEIGHT_W-1:0] frame_height_reg = ct3_pkg::FRAME_HEIGHT_RST;

    census_result_t census_expected [$];

    int          errors = 0;
    int unsigned pixels_sent = 0;
    int unsigned burst_left = 0;
    bit          sender_bursty = 1'b1;
    bit          hold_request = 1'b0;
    int unsigned idle_cycles = 0;

    census_transform_3x3_stream uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // effective frame size after saturation
    function automatic int unsigned eff_width();
        if (frame_width_reg < ct3_pkg::MIN_DIM)
            return ct3_pkg::MIN_DIM;
        if (frame_width_reg > FRAME_W_MAX)
            return FRAME_W_MAX;
        return 32'(frame_width_reg);
    endfunction

    function automatic int unsigned eff_height();
        if (frame_height_reg < ct3_pkg::MIN_DIM)
            return ct3_pkg::MIN_DIM;
        if (frame_height_reg > FRAME_H_MAX)
            return FRAME_H_MAX;
        return 32'(frame_height_reg);
    endfunction

    // pixels still to come before the current frame wraps
    function automatic int unsigned frame_remaining();
        return eff_width() * eff_height() - (row_pos * eff_width() + col_pos);
    endfunction

    // one accepted pixel: shift the window, update the line stores and queue
    // the census code of the centre that this pixel completes, if interior
    task automatic predict_census(input logic [ct3_pkg::PIX_W-1:0] bot);
        int unsigned               w;
        int unsigned               h;
        int unsigned               c;
        int unsigned               r;
        logic [ct3_pkg::PIX_W-1:0] top;
        logic [ct3_pkg::PIX_W-1:0] mid;
        logic [ct3_pkg::PIX_W-1:0] ctr;
        census_result_t            res;
        w = eff_width();
        h = eff_height();
        c = (col_pos >= w) ? w - 1 : col_pos;
        r = (row_pos >= h) ? h - 1 : row_pos;
        top = upper_line[c];
        mid = middle_line[c];
        upper_line[c]  = mid;
        middle_line[c] = bot;
        if (r >= 2 && c >= 2)
        begin
            ctr = window[4];
            // TL, T, TR, L, R, BL, B, BR with TL in the MSB
            res.code = {window[0] >= ctr, window[3] >= ctr, top >= ctr,
                        window[1] >= ctr, mid >= ctr,
                        window[2] >= ctr, window[5] >= ctr, bot >= ctr};
            res.row  = ct3_pkg::ROW_OUT_W'(r - 1);
            res.col  = ct3_pkg::COL_OUT_W'(c - 1);
            res.last = (r == h - 1) && (c == w - 1);
            census_expected.push_back(res);
        end
        window[0] = window[3];
        window[1] = window[4];
        window[2] = window[5];
        window[3] = top;
        window[4] = mid;
        window[5] = bot;
        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
            row_pos = r;
        end
    endtask

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // APB write: setup then access; a restart of the frame in the predictor.
    // Bits above the register width carry noise, the block must drop them.
    task automatic write_register(input ct3_pkg::ct3_reg_t idx, input int unsigned value);
        logic [ct3_pkg::APB_DATA_W-1:0] word;
        word = $urandom;
        if (idx == ct3_pkg::REG_FRAME_WIDTH)
            word[ct3_pkg::REG_WIDTH_W-1:0] = value[ct3_pkg::REG_WIDTH_W-1:0];
        else
            word[ct3_pkg::REG_HEIGHT_W-1:0] = value[ct3_pkg::REG_HEIGHT_W-1:0];
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == ct3_pkg::REG_FRAME_WIDTH)
            frame_width_reg = word[ct3_pkg::REG_WIDTH_W-1:0];
        else
            frame_height_reg = word[ct3_pkg::REG_HEIGHT_W-1:0];
        col_pos = 0;
        row_pos = 0;
        // bus returns to idle before the next transfer
        @(posedge clk);
    endtask

    // one pixel beat; in bursty mode a random gap opens between bursts
    task automatic send_pixel(input logic [ct3_pkg::PIX_W-1:0] value);
        if (sender_bursty && burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_census(value);
        pixels_sent++;
        if (burst_left > 0)
            burst_left--;
    endtask

    function automatic logic [ct3_pkg::PIX_W-1:0] pick_pixel(
        input pixel_style_t              style,
        input logic [ct3_pkg::PIX_W-1:0] level);
        case (style)
            STYLE_FLAT:    return level + ct3_pkg::PIX_W'($urandom_range(0, 2)) - 8'd1;
            STYLE_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default:       return ct3_pkg::PIX_W'($urandom);
        endcase
    endfunction

    task automatic send_pixels(input int unsigned count);
        pixel_style_t              style;
        logic [ct3_pkg::PIX_W-1:0] level;
        style = pixel_style_t'($urandom_range(0, 2));
        level = ct3_pkg::PIX_W'($urandom);
        repeat (count)
            send_pixel(pick_pixel(style, level));
    endtask

    // sender goes quiet until every queued census beat has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (census_expected.size() != 0)
            @(posedge clk);
    endtask

    // idle point for register writes: border pixels may still be in the pipe
    task automatic settle_block();
        drain_results();
        repeat (PIPE_SLACK)
            @(posedge clk);
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned h);
        settle_block();
        write_register(ct3_pkg::REG_FRAME_WIDTH, w);
        write_register(ct3_pkg::REG_FRAME_HEIGHT, h);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: ready pattern of its own, plus a long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin
        ready_mode_t mode;
        int unsigned phase;
        mode  = READY_ALWAYS;
        phase = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
            end
            phase++;
            if (phase % 50 == 0)
                mode = ready_mode_t'($urandom_range(0, 3));
            case (mode)
                READY_MOSTLY:   m_tready <= ($urandom_range(0, 3) != 0);
                READY_SPARSE:   m_tready <= ($urandom_range(0, 9) < 3);
                READY_PERIODIC: m_tready <= (phase % 4 != 0);
                default:        m_tready <= 1'b1;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Checker
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input int unsigned expv,
                                        input int unsigned act);
        if (expv != act)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, expv, act);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        census_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (census_expected.size() == 0)
            begin
                $error("census beat with nothing expected: tdata %h", m_tdata);
                errors++;
            end
            else
            begin
                want = census_expected.pop_front();
                check_field("census_code", want.code, m_tdata[7:0]);
                check_field("center_row", want.row, m_tdata[19:8]);
                check_field("center_column", want.col, m_tdata[29:20]);
                check_field("frame_last", want.last, m_tlast);
                check_field("tdata_padding", 0, m_tdata[31:30]);
            end
        end
    end

    // watchdog: any handshake on either stream or an APB write counts as progress
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable && pwrite && pready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // hand-built 3x3 frames: mixed compares with ties, all ties, all below
    task automatic test_census_bits();
        logic [ct3_pkg::PIX_W-1:0] frames [3][9];
        frames = '{'{8'd0,   8'd255, 8'd128, 8'd127, 8'd128, 8'd129, 8'd128, 8'd0,   8'd255},
                   '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
                   '{8'd254, 8'd254, 8'd254, 8'd254, 8'd255, 8'd254, 8'd254, 8'd254, 8'd254}};
        write_register(ct3_pkg::REG_FRAME_WIDTH, ct3_pkg::MIN_DIM);
        write_register(ct3_pkg::REG_FRAME_HEIGHT, ct3_pkg::MIN_DIM);
        foreach (frames[f, p])
            send_pixel(frames[f][p]);
    endtask

    // sizes below the minimum saturate to 3x3
    task automatic test_size_saturation();
        set_frame(1, 0);
        send_pixels(2 * frame_remaining());
        set_frame(2, 2);
        send_pixels(frame_remaining());
    endtask

    // wide frame, column numbers well past the small-frame range
    task automatic test_wide_frame();
        set_frame(WIDE_W, ct3_pkg::MIN_DIM);
        send_pixels(frame_remaining());
    endtask

    // tall frame on a saturated narrow width
    task automatic test_tall_frame();
        set_frame(0, TALL_H);
        send_pixels(frame_remaining());
    endtask

    // register writes in mid-frame restart the raster, once before any
    // result and once with interior rows under way
    task automatic test_restart_mid_frame();
        set_frame(FRAME_W_MAX, 8191);
        send_pixels(40);
        set_frame(7, 5);
        send_pixels(20);
        settle_block();
        write_register(ct3_pkg::REG_FRAME_HEIGHT, 6);
        send_pixels(2 * frame_remaining());
    endtask

    // receiver holds off long enough for the block to fill and stall its input
    task automatic test_backpressure();
        set_frame(8, 8);
        sender_bursty = 1'b0;
        hold_request  = 1'b1;
        send_pixels(2 * frame_remaining());
        sender_bursty = 1'b1;
    endtask

    // sender stops mid-frame until the output has caught up, then resumes
    task automatic test_pause_for_results();
        send_pixels(30);
        drain_results();
        send_pixels(frame_remaining());
    endtask

    // mostly small frames of random size and content; some cut short by a
    // reconfigure, some paused part way, some sent without idling
    task automatic test_random_frames();
        int unsigned start;
        int unsigned w;
        int unsigned h;
        start = pixels_sent;
        while (pixels_sent - start < RANDOM_PIXELS)
        begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
            h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
            settle_block();
            if ($urandom_range(0, 3) != 0)
                write_register(ct3_pkg::REG_FRAME_WIDTH, w);
            write_register(ct3_pkg::REG_FRAME_HEIGHT, h);
            sender_bursty = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 3))
            begin
                if ($urandom_range(0, 5) == 0)
                begin
                    send_pixels($urandom_range(1, frame_remaining() - 1));
                    drain_results();
                end
                send_pixels(frame_remaining());
            end
            if ($urandom_range(0, 4) == 0)
                send_pixels($urandom_range(1, frame_remaining() - 1));
        end
        sender_bursty = 1'b1;
    endtask

    initial
    begin
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_census_bits();
        test_size_saturation();
        test_wide_frame();
        test_tall_frame();
        test_restart_mid_frame();
        test_backpressure();
        test_pause_for_results();
        test_random_frames();

        drain_results();
        repeat (PIPE_SLACK)
            @(posedge clk);
        if (census_expected.size() != 0)
        begin
            $error("%0d census beats never arrived", census_expected.size());
            errors++;
        end
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/ct3_pkg.sv
rtl/ct3_core.sv
rtl/census_transform_3x3_stream.sv
rtl/ct3_checker.sv
sim/census_transform_3x3_stream_tb.sv
